>>> design/sws_pkg.sv
// shared types and constants for the sliding window smoother
package sws_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int ACC_W      = 64;
    localparam int PROD_SHIFT = 6;
    localparam int OUT_SHIFT  = 24;
    localparam int QUOT_W     = ACC_W + 1 - OUT_SHIFT;
    localparam int QCNT_W     = 6;
    localparam int IDX_W      = 5;
    localparam int ACTION_W   = 2;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH  = 2'd0,
        ACT_FLUSH = 2'd1,
        ACT_LOAD  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DIV,
        ST_OUT
    } sws_state_t;

endpackage

>>> design/sliding_window_smoother.sv
// top level: control sequencer, window bookkeeping and output register
// a push with too few samples or a load gives no result
// each result passes one tap per cycle through the
// multiply-accumulate memory loop, then a one-bit-per-cycle 41-step divider
// a flush gives WINDOW_LEN/2 results one after another; one item at a time
// reset (rst_n, async low) empties the window, clears the result count; coefficients keep
module sliding_window_smoother #(
    parameter int WINDOW_LEN = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // sample_value[31:0], coef_index[36:32], coef_value[68:37], zero pad
    input  logic [sws_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // action[1:0]
    input  logic [sws_pkg::ACTION_W-1:0]         s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // filtered_value[31:0], output_index[63:32]
    output logic [sws_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // last_of_run
    output logic                                 m_axis_tlast
);
    import sws_pkg::*;

    localparam int AW   = $clog2(WINDOW_LEN);
    localparam int PW   = $clog2(2*WINDOW_LEN);
    localparam int CW   = $clog2(WINDOW_LEN+1);
    localparam int HALF = WINDOW_LEN / 2;

    sws_state_t state_reg, state_next;

    // window bookkeeping: write pointer names the oldest slot (next to overwrite)
    logic [AW-1:0]        wptr_reg;
    logic [CW-1:0]        seen_reg;
    logic [SAMPLE_W-1:0]  emitted_reg;

    // current run of results
    logic                 flush_reg;
    logic                 last_reg;
    logic [CW-1:0]        shift_reg;
    logic [CW-1:0]        count_reg;
    logic [AW-1:0]        slot_reg;
    logic [PW-1:0]        pos_reg;
    logic [CW-1:0]        first_reg;
    logic                 mac_go_reg;

    // output register
    logic [SAMPLE_W-1:0]  out_value_reg;
    logic [SAMPLE_W-1:0]  out_index_reg;
    logic                 out_last_reg;

    // input field decode
    action_t              action;
    logic [SAMPLE_W-1:0]  sample_value;
    logic [IDX_W-1:0]     coef_index;
    logic [SAMPLE_W-1:0]  coef_value;
    logic                 in_xfer;
    logic                 out_xfer;
    logic [CW-1:0]        seen_inc;
    logic                 push_fires;
    logic                 flush_fires;
    logic                 coef_ok;
    logic                 more_tail;

    logic                 mac_done;
    logic signed [ACC_W-1:0] mac_acc;
    logic                 div_done;
    logic [SAMPLE_W-1:0]  div_result;

    function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
        return (s == AW'(WINDOW_LEN-1)) ? '0 : s + AW'(1);
    endfunction

    assign action       = action_t'(s_axis_tuser);
    assign sample_value = s_axis_tdata[31:0];
    assign coef_index   = s_axis_tdata[36:32];
    assign coef_value   = s_axis_tdata[68:37];

    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign out_xfer   = m_axis_tvalid && m_axis_tready;
    assign seen_inc   = (seen_reg == CW'(WINDOW_LEN)) ? seen_reg : seen_reg + CW'(1);
    assign push_fires = (action == ACT_PUSH) && (seen_inc >= CW'(HALF));
    assign flush_fires = (action == ACT_FLUSH) && (seen_reg == CW'(WINDOW_LEN));
    assign coef_ok    = ({1'b0, coef_index} < (IDX_W+1)'(WINDOW_LEN));
    assign more_tail  = flush_reg && !last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && (push_fires || flush_fires))
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (mac_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                begin
                    state_next = more_tail ? ST_MAC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_OUT:  m_axis_tvalid = 1'b1;
            default:
            begin
                s_axis_tready = 1'b0;
                m_axis_tvalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            wptr_reg    <= '0;
            seen_reg    <= '0;
            emitted_reg <= '0;
            mac_go_reg  <= 1'b0;
            flush_reg   <= 1'b0;
            last_reg    <= 1'b0;
            shift_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            mac_go_reg <= 1'b0;
            if (in_xfer && (action == ACT_PUSH))
            begin
                wptr_reg <= slot_inc(wptr_reg);
                seen_reg <= seen_inc;
                flush_reg <= 1'b0;
                last_reg  <= 1'b1;
                shift_reg <= '0;
                mac_go_reg <= push_fires;
            end
            else if (in_xfer && flush_fires)
            begin
                flush_reg  <= 1'b1;
                last_reg   <= (HALF == 1);
                shift_reg  <= CW'(1);
                mac_go_reg <= 1'b1;
            end
            if (div_done)
            begin
                emitted_reg <= emitted_reg + SAMPLE_W'(1);
            end
            if (out_xfer && more_tail)
            begin
                shift_reg  <= shift_reg + CW'(1);
                last_reg   <= (shift_reg + CW'(1)) == CW'(HALF);
                mac_go_reg <= 1'b1;
            end
        end
    end

    // run parameters for the multiply-accumulate pass
    always_ff @(posedge clk)
    begin
        if (in_xfer && (action == ACT_PUSH))
        begin
            // push: window starts at the oldest slot, leading zeros before the fill
            slot_reg  <= slot_inc(wptr_reg);
            pos_reg   <= '0;
            first_reg <= CW'(WINDOW_LEN) - seen_inc;
            count_reg <= seen_inc;
        end
        else if (in_xfer && flush_fires)
        begin
            // first tail step drops the oldest sample, zeros at the end
            slot_reg  <= slot_inc(wptr_reg);
            pos_reg   <= PW'(1);
            first_reg <= '0;
            count_reg <= CW'(WINDOW_LEN-1);
        end
        else if (out_xfer && more_tail)
        begin
            slot_reg  <= slot_inc(slot_reg);
            pos_reg   <= PW'(shift_reg) + PW'(1);
            count_reg <= count_reg - CW'(1);
        end
        if (div_done)
        begin
            out_value_reg <= div_result;
            out_index_reg <= emitted_reg + SAMPLE_W'(1);
            out_last_reg  <= last_reg;
        end
    end

    sws_mac #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .samp_we    (in_xfer && (action == ACT_PUSH)),
        .samp_waddr (wptr_reg),
        .samp_wdata (sample_value),
        .coef_we    (in_xfer && (action == ACT_LOAD) && coef_ok),
        .coef_waddr (AW'(coef_index)),
        .coef_wdata (coef_value),
        .start      (mac_go_reg),
        .start_slot (slot_reg),
        .start_pos  (pos_reg),
        .first_pos  (first_reg),
        .done       (mac_done),
        .acc        (mac_acc)
    );

    sws_div #(
        .CNT_W (CW)
    ) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mac_done),
        .acc_in (mac_acc),
        .count  (count_reg),
        .done   (div_done),
        .result (div_result)
    );

    assign m_axis_tdata = {out_index_reg, out_value_reg};
    assign m_axis_tlast = out_last_reg;

    a_seen_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= CW'(WINDOW_LEN))
        else $error("sample count beyond window length");

    a_wptr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        wptr_reg < AW'(WINDOW_LEN) || (1 << AW) == WINDOW_LEN)
        else $error("write pointer outside window");

    a_mac_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |=> state_reg == ST_DIV)
        else $error("accumulate finished outside its state");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");

    a_done_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(mac_done && div_done))
        else $error("accumulate and divide finished together");

endmodule

>>> design/sws_mac.sv
// sample and coefficient memories with the multiply-accumulate sequencer
module sws_mac #(
    parameter int WINDOW_LEN = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   samp_we,
    input  logic [$clog2(WINDOW_LEN)-1:0]          samp_waddr,
    input  logic signed [sws_pkg::SAMPLE_W-1:0]    samp_wdata,
    input  logic                                   coef_we,
    input  logic [$clog2(WINDOW_LEN)-1:0]          coef_waddr,
    input  logic signed [sws_pkg::SAMPLE_W-1:0]    coef_wdata,
    input  logic                                   start,
    input  logic [$clog2(WINDOW_LEN)-1:0]          start_slot,
    input  logic [$clog2(2*WINDOW_LEN)-1:0]        start_pos,
    input  logic [$clog2(WINDOW_LEN+1)-1:0]        first_pos,
    output logic                                   done,
    output logic signed [sws_pkg::ACC_W-1:0]       acc
);
    import sws_pkg::*;

    localparam int AW = $clog2(WINDOW_LEN);
    localparam int PW = $clog2(2*WINDOW_LEN);
    localparam int CW = $clog2(WINDOW_LEN+1);

    logic signed [SAMPLE_W-1:0] samp_mem [WINDOW_LEN];
    logic signed [SAMPLE_W-1:0] coef_mem [WINDOW_LEN];
    logic signed [SAMPLE_W-1:0] samp_rd_reg;
    logic signed [SAMPLE_W-1:0] coef_rd_reg;

    logic          busy_reg;
    logic [AW-1:0] tap_reg;
    logic [AW-1:0] slot_reg;
    logic [PW-1:0] pos_reg;
    logic [CW-1:0] first_reg;
    logic          s1_vld_reg, s1_zero_reg, s1_last_reg;
    logic          p2_vld_reg, p2_last_reg;
    logic signed [ACC_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic          done_reg;
    logic          tap_zero;

    assign tap_zero = !((pos_reg < PW'(WINDOW_LEN)) && (pos_reg >= PW'(first_reg)));

    always_ff @(posedge clk)
    begin
        if (samp_we)
        begin
            samp_mem[samp_waddr] <= samp_wdata;
        end
        samp_rd_reg <= samp_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we)
        begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        coef_rd_reg <= coef_mem[tap_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            s1_vld_reg  <= 1'b0;
            s1_last_reg <= 1'b0;
            p2_vld_reg  <= 1'b0;
            p2_last_reg <= 1'b0;
            done_reg    <= 1'b0;
            tap_reg     <= '0;
            slot_reg    <= '0;
            pos_reg     <= '0;
            first_reg   <= '0;
        end
        else
        begin
            s1_vld_reg  <= busy_reg;
            s1_last_reg <= busy_reg && (tap_reg == AW'(WINDOW_LEN-1));
            p2_vld_reg  <= s1_vld_reg;
            p2_last_reg <= s1_vld_reg && s1_last_reg;
            done_reg    <= p2_vld_reg && p2_last_reg;
            if (start)
            begin
                busy_reg  <= 1'b1;
                tap_reg   <= '0;
                slot_reg  <= start_slot;
                pos_reg   <= start_pos;
                first_reg <= first_pos;
            end
            else if (busy_reg)
            begin
                tap_reg  <= tap_reg + AW'(1);
                slot_reg <= (slot_reg == AW'(WINDOW_LEN-1)) ? '0 : slot_reg + AW'(1);
                pos_reg  <= pos_reg + PW'(1);
                if (tap_reg == AW'(WINDOW_LEN-1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // payload pipeline: product register, then accumulate floor(product / 64)
    always_ff @(posedge clk)
    begin
        s1_zero_reg <= tap_zero;
        prod_reg    <= s1_zero_reg ? '0 : ACC_W'(samp_rd_reg * coef_rd_reg);
        if (start)
        begin
            acc_reg <= '0;
        end
        else if (p2_vld_reg)
        begin
            acc_reg <= acc_reg + (prod_reg >>> PROD_SHIFT);
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

>>> design/sws_div.sv
// rounded division of the sum by count times 2^24, with saturation
module sws_div #(
    parameter int CNT_W = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [sws_pkg::ACC_W-1:0]    acc_in,
    input  logic [CNT_W-1:0]                    count,
    output logic                                done,
    output logic [sws_pkg::SAMPLE_W-1:0]        result
);
    import sws_pkg::*;

    logic                  prep_reg, run_reg, fin_reg, done_reg;
    logic [QCNT_W-1:0]     cnt_reg;
    logic                  neg_reg;
    logic [ACC_W-1:0]      mag_reg;
    logic [CNT_W-1:0]      den_reg;
    logic [QUOT_W-1:0]     num_reg;
    logic [QUOT_W-1:0]     quo_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [SAMPLE_W-1:0]   result_reg;
    logic [ACC_W:0]        biased;
    logic [CNT_W:0]        rem_try;
    logic                  fits;

    // adding half the divisor before the floor gives round half away from zero
    assign biased  = {1'b0, mag_reg} + ((ACC_W+1)'(den_reg) << (OUT_SHIFT-1));
    assign rem_try = {rem_reg, num_reg[QUOT_W-1]};
    assign fits    = rem_try >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_reg <= 1'b0;
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            prep_reg <= start;
            fin_reg  <= run_reg && (cnt_reg == QCNT_W'(1));
            done_reg <= fin_reg;
            if (prep_reg)
            begin
                run_reg <= 1'b1;
                cnt_reg <= QCNT_W'(QUOT_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
                if (cnt_reg == QCNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= acc_in[ACC_W-1];
            mag_reg <= acc_in[ACC_W-1] ? ACC_W'(-acc_in) : ACC_W'(acc_in);
            den_reg <= count;
        end
        if (prep_reg)
        begin
            num_reg <= biased[ACC_W:OUT_SHIFT];
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[QUOT_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUOT_W-2:0], fits};
            rem_reg <= fits ? CNT_W'(rem_try - {1'b0, den_reg}) : CNT_W'(rem_try);
        end
        if (fin_reg)
        begin
            if (neg_reg)
            begin
                result_reg <= (quo_reg > QUOT_W'(33'h080000000)) ? 32'h80000000
                                                                 : -quo_reg[SAMPLE_W-1:0];
            end
            else
            begin
                result_reg <= (quo_reg > QUOT_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                                                                : quo_reg[SAMPLE_W-1:0];
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> test/tb_top.sv
// testbench for the sliding window smoother: table of directed items, then random items
module tb_top;
    import sws_pkg::*;

    localparam int WIN       = 32;
    localparam int HALF      = WIN / 2;
    localparam int N_RANDOM  = 36;
    localparam int LIMIT     = 3000000;
    localparam int HOLD_LEN  = 2000;
    localparam int TAIL_WAIT = 200;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [ACTION_W-1:0]   s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    sliding_window_smoother #(.WINDOW_LEN(WIN)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // one smoothed value as it leaves the block
    typedef struct {
        logic [31:0] value;
        logic [31:0] index;
        logic        last;
    } smoothed_t;

    // one row of the directed table; typed marks a value read off by hand
    typedef struct {
        action_t     act;
        logic [31:0] sample;
        logic [4:0]  idx;
        logic [31:0] cval;
        bit          typed;
        logic [31:0] tval;
    } step_row_t;

    // local copy of the block state
    logic signed [31:0] window_mirror [WIN];
    logic signed [31:0] coef_mirror [WIN];
    int unsigned        seen_count;
    logic [31:0]        emitted_count;

    smoothed_t   pending_results[$];
    int          fails;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    int          hold_cycles;
    int unsigned cycle_count;

    // typed expectation for the transfer currently offered
    bit          cur_typed;
    logic [31:0] cur_tval;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // weighted mean of a window: Q.30 products floored to Q.24, rounded divide, saturated
    function automatic logic [31:0] weighted_mean(logic signed [31:0] w [WIN],
                                                  int unsigned cnt);
        longint      acc;
        longint      prod;
        bit          neg;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        acc = 0;
        for (int j = 0; j < WIN; j++)
        begin
            prod = longint'(w[j]) * longint'(coef_mirror[j]);
            acc += prod >>> PROD_SHIFT;
        end
        neg = acc < 0;
        mag = neg ? longint'(-acc) : acc;
        den = longint'(cnt) << OUT_SHIFT;
        q = (mag + den / 2) / den;
        if (neg)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic void queue_result(logic [31:0] v, bit last);
        smoothed_t r;
        emitted_count++;
        r.value = v;
        r.index = emitted_count;
        r.last  = last;
        pending_results.push_back(r);
    endfunction

    // advance the local state by one accepted item
    function automatic void predict_item(action_t act, logic [31:0] smp,
                                         logic [4:0] idx, logic [31:0] cv);
        logic signed [31:0] tail [WIN];
        case (act)
            ACT_PUSH:
            begin
                for (int j = 0; j < WIN - 1; j++)
                    window_mirror[j] = window_mirror[j + 1];
                window_mirror[WIN - 1] = smp;
                if (seen_count < WIN)
                    seen_count++;
                if (seen_count >= HALF)
                    queue_result(cur_typed ? cur_tval
                                 : weighted_mean(window_mirror, seen_count), 1'b1);
            end
            ACT_FLUSH:
            begin
                // tail only once the window is full, newest samples slide to the front
                if (seen_count == WIN)
                    for (int i = 1; i <= HALF; i++)
                    begin
                        for (int j = 0; j < WIN; j++)
                            tail[j] = (j < WIN - i) ? window_mirror[j + i] : '0;
                        queue_result(weighted_mean(tail, WIN - i), i == HALF);
                    end
            end
            ACT_LOAD:
                coef_mirror[idx] = cv;
            default: ;
        endcase
    endfunction

    // input monitor: every accepted transfer feeds the predictor
    always @(posedge clk)
        if (rst_n && s_axis_tvalid && s_axis_tready)
            predict_item(action_t'(s_axis_tuser), s_axis_tdata[31:0],
                         s_axis_tdata[36:32], s_axis_tdata[68:37]);

    // output checker against the oldest pending result
    always @(posedge clk)
    begin
        smoothed_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, actual value %h index %0d last %b",
                         $time, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
                fails++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== e.value)
                begin
                    $display("%0t: filtered_value expected %h actual %h",
                             $time, e.value, m_axis_tdata[31:0]);
                    fails++;
                end
                if (m_axis_tdata[63:32] !== e.index)
                begin
                    $display("%0t: output_index expected %0d actual %0d",
                             $time, e.index, m_axis_tdata[63:32]);
                    fails++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, e.last, m_axis_tlast);
                    fails++;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold counted here
    always @(posedge clk or negedge rst_n)
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= 0;
        end
        else if (hold_req && hold_cycles < HOLD_LEN)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles + 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // offer one transfer, sometimes after a random gap, and wait for the handshake
    task automatic send_item(action_t act, logic [31:0] smp, logic [4:0] idx,
                             logic [31:0] cv);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, cv, idx, smp};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_random;
        int          pick;
        action_t     act;
        logic [31:0] smp;
        pick = $urandom_range(99);
        if (pick < 72)
            act = ACT_PUSH;
        else if (pick < 80)
            act = ACT_FLUSH;
        else if (pick < 94)
            act = ACT_LOAD;
        else
            act = ACT_NONE;
        // mostly moderate samples, sometimes the full range
        smp = ($urandom_range(3) == 0) ? $urandom() : 32'($signed($urandom_range(0, 32'h0FFF_FFFF))
              - 32'sh0800_0000);
        send_item(act, smp, 5'($urandom_range(WIN - 1)), $urandom());
    endtask

    step_row_t directed_rows[$];

    initial
    begin
        step_row_t row;
        fails          = 0;
        cycle_count    = 0;
        hold_req       = 1'b0;
        send_idle_pct  = 36;
        recv_stall_pct = 55;
        cur_typed      = 1'b0;
        cur_tval       = '0;
        seen_count     = 0;
        emitted_count  = '0;
        for (int j = 0; j < WIN; j++)
        begin
            window_mirror[j] = '0;
            coef_mirror[j]   = '0;
        end
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_PUSH;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every coefficient written with zero so no unwritten entry is ever read
        for (int j = 0; j < WIN; j++)
            send_item(ACT_LOAD, '0, 5'(j), '0);

        // directed table: warm-up pushes at the sample extremes, no result until half full
        for (int k = 0; k < HALF - 1; k++)
            directed_rows.push_back('{ACT_PUSH, (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                                      '0, '0, 1'b0, '0});
        // first result: all coefficients zero gives zero
        directed_rows.push_back('{ACT_PUSH, 32'h7FFF_FFFF, '0, '0, 1'b1, 32'h0});
        // flush while the window is not yet full does nothing
        directed_rows.push_back('{ACT_FLUSH, '0, '0, '0, 1'b0, '0});
        // unused action code is ignored
        directed_rows.push_back('{ACT_NONE, 32'hFFFF_FFFF, 5'h1F, 32'hFFFF_FFFF, 1'b0, '0});
        // unit weight on the newest tap: 1.0 over 17 samples
        directed_rows.push_back('{ACT_LOAD, '0, 5'd31, 32'h4000_0000, 1'b0, '0});
        directed_rows.push_back('{ACT_PUSH, 32'h0001_0000, '0, '0, 1'b1, 32'd3855});
        // coefficient extremes on both ends
        directed_rows.push_back('{ACT_LOAD, '0, 5'd0, 32'h8000_0000, 1'b0, '0});
        directed_rows.push_back('{ACT_LOAD, '0, 5'd30, 32'h7FFF_FFFF, 1'b0, '0});
        directed_rows.push_back('{ACT_PUSH, 32'h8000_0000, '0, '0, 1'b0, '0});
        directed_rows.push_back('{ACT_PUSH, 32'h7FFF_FFFF, '0, '0, 1'b0, '0});

        // typed expectation changes after the edge so the monitor sees the current row
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            cur_typed <= row.typed;
            cur_tval  <= row.tval;
            send_item(row.act, row.sample, row.idx, row.cval);
        end
        cur_typed <= 1'b0;

        // fill the window so the flush tail can be reached, then random coefficients
        for (int k = 0; k < WIN; k++)
            send_item(ACT_PUSH, $urandom(), '0, '0);
        for (int j = 0; j < WIN; j++)
            send_item(ACT_LOAD, '0, 5'(j), $urandom());
        send_item(ACT_FLUSH, '0, '0, '0);

        // long receiver hold while the sender keeps offering
        hold_req = 1'b1;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 3)
            begin
                send_idle_pct  = 55;
                recv_stall_pct = 36;
            end
            if (n == N_RANDOM / 2)
            begin
                // sender pauses until the block has drained
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                wait (pending_results.size() == 0);
                repeat (4) @(posedge clk);
            end
            if (n == 2 * N_RANDOM / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            send_random();
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        wait (pending_results.size() == 0);
        repeat (TAIL_WAIT) @(posedge clk);
        if (fails == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
